>>> rtl/core/fra_pkg.sv
// fra_pkg: shared types, constants and helpers of the fenced ring allocator
// used by fenced_ring_allocator; no dependencies
package fra_pkg;

    localparam int FENCE_DEPTH = 16;
    localparam int FIDX_W      = $clog2(FENCE_DEPTH);
    localparam int CNT_W       = FIDX_W + 1;
    localparam int OFS_W       = 27;
    localparam int FENCE_W     = 64;
    localparam int ENTRY_W     = FENCE_W + OFS_W;

    typedef logic [OFS_W-1:0]   ofs_t;
    typedef logic [OFS_W:0]     wide_t;
    typedef logic [FENCE_W-1:0] fence_t;

    // operation codes
    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_COMMIT  = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_OVERRUN  = 2'd3;

    // register indexes
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_GPU_BACKED  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NEWEST,
        S_RET_RD,
        S_RET_EV,
        S_PUSH,
        S_PLACE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ALIGN,
        S_RESP
    } state_t;

    // difference clamped at zero
    function automatic ofs_t sub_sat(input ofs_t a, input ofs_t b);
        sub_sat = (a > b) ? ofs_t'(a - b) : '0;
    endfunction

    // round up to a power-of-two boundary, wrapping at the offset width
    function automatic ofs_t align_up(input ofs_t x, input logic [3:0] sh);
        wide_t m;
        wide_t s;
        m = (wide_t'(1) << sh) - wide_t'(1);
        s = ({1'b0, x} + m) & ~m;
        align_up = s[OFS_W-1:0];
    endfunction

endpackage

>>> rtl/core/fra_ram.sv
// fra_ram: generic single-write, single-read ram with registered read data
// no dependencies
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/fenced_ring_allocator.sv
// fenced_ring_allocator: top level, sequencer and datapath of the allocator
// depends on fra_pkg and fra_ram (fence queue storage)
//
// usage
// - input channel (in_valid/in_ready) carries one operation per transfer:
//   reserve, commit, flush or clear; in_ready is high only while idle
// - output channel (out_valid/out_ready) returns one result per transfer;
//   a flush that wraps returns two, the second with last set
// - the fence queue is a 16-entry ring in fra_ram with one registered read
//   port; every queue visit takes an address state, then a compare state
// - commit, flush, clear and oversized reserve go from decode to the result
// - reserve: may check the newest entry, retire completed fences, push the
//   current fence and place, and if needed scan the queue and align
// - one item is in flight at a time; a stalled receiver holds the result
//   and the block accepts nothing until the last result is transferred
// - reset clears offsets, queue count and registers; queue contents are
//   left as they are and only entries below the count are ever read
// - the user is to write configuration over the apb port only while the block is idle; not enforced
module fenced_ring_allocator
    import fra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [OFS_W-1:0]   byte_count,
    input  logic [3:0]         align_shift,
    input  logic [FENCE_W-1:0] current_fence,
    input  logic [FENCE_W-1:0] completed_fence,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [OFS_W-1:0]   write_offset,
    output logic [OFS_W-1:0]   free_space,
    output logic               wait_valid,
    output logic [FENCE_W-1:0] wait_fence,
    output logic               copy_valid,
    output logic [OFS_W-1:0]   copy_start,
    output logic [OFS_W-1:0]   copy_length,
    output logic               last
);

    state_t            state_reg, state_next;
    ofs_t              write_pos_reg, write_pos_next;
    ofs_t              space_left_reg, space_left_next;
    ofs_t              retired_pos_reg, retired_pos_next;
    ofs_t              copied_pos_reg, copied_pos_next;
    logic [FIDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    ofs_t              buffer_size_reg;
    logic              gpu_backed_reg;
    logic              second_reg, second_next;

    logic [1:0]        op_reg, op_next;
    ofs_t              nb_reg, nb_next;
    logic [3:0]        ash_reg, ash_next;
    fence_t            cur_reg, cur_next;
    fence_t            done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic              wait_valid_reg, wait_valid_next;
    fence_t            wait_fence_reg, wait_fence_next;
    logic              copy_valid_reg, copy_valid_next;
    ofs_t              copy_start_reg, copy_start_next;
    ofs_t              copy_length_reg, copy_length_next;
    logic              last_reg, last_next;

    // queue ram ports
    logic              q_we;
    logic [FIDX_W-1:0] q_waddr, q_raddr;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;
    fence_t            rd_fence;
    ofs_t              rd_ofs;

    // shared arithmetic terms
    wide_t             req;
    ofs_t              aligned;
    ofs_t              room_end;
    logic [CNT_W-1:0]  cnt_left;
    logic [CNT_W-1:0]  cnt_cap;
    logic [FIDX_W-1:0] head_new;
    logic [CNT_W-1:0]  drop_n;

    fra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FENCE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign rd_fence = q_rdata[ENTRY_W-1:OFS_W];
    assign rd_ofs   = q_rdata[OFS_W-1:0];

    assign req      = {1'b0, nb_reg} + (wide_t'(1) << ash_reg);
    assign aligned  = align_up(write_pos_reg, ash_reg);
    assign room_end = sub_sat(buffer_size_reg, write_pos_reg);
    assign cnt_left = count_reg - idx_reg;
    assign cnt_cap  = (cnt_left >= CNT_W'(FENCE_DEPTH)) ? CNT_W'(FENCE_DEPTH - 1) : cnt_left;
    assign head_new = head_reg + idx_reg[FIDX_W-1:0];
    assign drop_n   = idx_reg + CNT_W'(1);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GPU_BACKED) ? {31'b0, gpu_backed_reg}
                                                 : {{(32 - OFS_W){1'b0}}, buffer_size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= '0;
            gpu_backed_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_BUFFER_SIZE)
            begin
                buffer_size_reg <= pwdata[OFS_W-1:0];
            end
            else
            begin
                gpu_backed_reg <= pwdata[0];
            end
        end
    end

    // handshake and result ports
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_RESP);
    assign status       = status_reg;
    assign write_offset = write_pos_reg;
    assign free_space   = space_left_reg;
    assign wait_valid   = wait_valid_reg;
    assign wait_fence   = wait_fence_reg;
    assign copy_valid   = copy_valid_reg;
    assign copy_start   = copy_start_reg;
    assign copy_length  = copy_length_reg;
    assign last         = last_reg;

    // sequencer: next state, datapath updates and queue accesses
    always_comb
    begin
        state_next       = state_reg;
        write_pos_next   = write_pos_reg;
        space_left_next  = space_left_reg;
        retired_pos_next = retired_pos_reg;
        copied_pos_next  = copied_pos_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        second_next      = second_reg;
        op_next          = op_reg;
        nb_next          = nb_reg;
        ash_next         = ash_reg;
        cur_next         = cur_reg;
        done_next        = done_reg;
        status_next      = status_reg;
        wait_valid_next  = wait_valid_reg;
        wait_fence_next  = wait_fence_reg;
        copy_valid_next  = copy_valid_reg;
        copy_start_next  = copy_start_reg;
        copy_length_next = copy_length_reg;
        last_next        = last_reg;
        q_we             = 1'b0;
        q_waddr          = head_reg + count_reg[FIDX_W-1:0] - FIDX_W'(1);
        q_wdata          = {cur_reg, write_pos_reg};
        q_raddr          = head_reg + idx_reg[FIDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    nb_next    = byte_count;
                    ash_next   = align_shift;
                    cur_next   = current_fence;
                    done_next  = completed_fence;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next      = ST_OK;
                wait_valid_next  = 1'b0;
                wait_fence_next  = '0;
                copy_valid_next  = 1'b0;
                copy_start_next  = '0;
                copy_length_next = '0;
                last_next        = 1'b1;
                second_next      = 1'b0;
                state_next       = S_RESP;
                case (op_reg)
                    OP_RESERVE:
                    begin
                        idx_next = '0;
                        if (nb_reg > buffer_size_reg)
                        begin
                            status_next = ST_TOO_BIG;
                        end
                        else if (write_pos_reg == retired_pos_reg)
                        begin
                            state_next = S_PLACE;
                        end
                        else if (count_reg != '0)
                        begin
                            // fetch the newest entry
                            q_raddr    = head_reg + count_reg[FIDX_W-1:0] - FIDX_W'(1);
                            state_next = S_NEWEST;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (({1'b0, write_pos_reg} + {1'b0, nb_reg}) > {1'b0, buffer_size_reg}
                            || nb_reg > space_left_reg)
                        begin
                            status_next = ST_OVERRUN;
                        end
                        else
                        begin
                            write_pos_next  = write_pos_reg + nb_reg;
                            space_left_next = space_left_reg - nb_reg;
                        end
                    end
                    OP_FLUSH:
                    begin
                        if (gpu_backed_reg && space_left_reg != buffer_size_reg)
                        begin
                            copied_pos_next = write_pos_reg;
                            copy_valid_next = 1'b1;
                            copy_start_next = copied_pos_reg;
                            if (copied_pos_reg < write_pos_reg)
                            begin
                                copy_length_next = write_pos_reg - copied_pos_reg;
                            end
                            else
                            begin
                                copy_length_next = sub_sat(buffer_size_reg, copied_pos_reg);
                                last_next        = 1'b0;
                                second_next      = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        write_pos_next   = '0;
                        space_left_next  = '0;
                        retired_pos_next = '0;
                        copied_pos_next  = '0;
                        count_next       = '0;
                    end
                endcase
            end

            // newest entry already carries this fence: move its offset
            S_NEWEST:
            begin
                if (rd_fence == cur_reg)
                begin
                    q_we       = 1'b1;
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_RET_RD;
                end
            end

            // retire completed fences from the oldest end
            S_RET_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_RET_EV : S_PUSH;
            end

            S_RET_EV:
            begin
                if (done_reg >= rd_fence)
                begin
                    retired_pos_next = rd_ofs;
                    idx_next         = idx_reg + CNT_W'(1);
                    state_next       = S_RET_RD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            // drop retired entries and append the current fence
            S_PUSH:
            begin
                head_next  = head_new;
                q_we       = 1'b1;
                q_waddr    = head_new + cnt_cap[FIDX_W-1:0];
                count_next = cnt_cap + CNT_W'(1);
                state_next = S_PLACE;
            end

            // try after the write offset, then the start, then the gap
            S_PLACE:
            begin
                idx_next   = '0;
                state_next = S_RESP;
                if (write_pos_reg >= retired_pos_reg)
                begin
                    if (((write_pos_reg != '0) ? req : {1'b0, nb_reg}) <= {1'b0, room_end})
                    begin
                        write_pos_next  = aligned;
                        space_left_next = sub_sat(buffer_size_reg, aligned);
                    end
                    else if (req < {1'b0, retired_pos_reg})
                    begin
                        write_pos_next  = '0;
                        space_left_next = retired_pos_reg;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (req < {1'b0, ofs_t'(retired_pos_reg - write_pos_reg)})
                begin
                    write_pos_next  = aligned;
                    space_left_next = sub_sat(retired_pos_reg, aligned);
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end

            // scan the queue for a fence worth waiting on
            S_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_SCAN_EV;
                end
                else
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_RESP;
                end
            end

            S_SCAN_EV:
            begin
                logic hit;
                ofs_t no;
                ofs_t ns;
                ofs_t nr;
                hit = 1'b0;
                no  = '0;
                ns  = '0;
                nr  = '0;
                if (write_pos_reg == rd_ofs)
                begin
                    hit = 1'b1;
                    ns  = buffer_size_reg;
                end
                else if (write_pos_reg > rd_ofs)
                begin
                    if ({1'b0, room_end} >= req)
                    begin
                        hit = 1'b1;
                        no  = write_pos_reg;
                        ns  = room_end;
                        nr  = rd_ofs;
                    end
                    else if ({1'b0, rd_ofs} > req)
                    begin
                        hit = 1'b1;
                        ns  = rd_ofs;
                        nr  = rd_ofs;
                    end
                end
                else if ({1'b0, ofs_t'(rd_ofs - write_pos_reg)} > req)
                begin
                    hit = 1'b1;
                    no  = write_pos_reg;
                    ns  = rd_ofs - write_pos_reg;
                    nr  = rd_ofs;
                end

                if (!hit)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
                else if (rd_fence == cur_reg)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_RESP;
                end
                else
                begin
                    if (write_pos_reg == rd_ofs || drop_n >= count_reg)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg - drop_n;
                        head_next  = head_reg + drop_n[FIDX_W-1:0];
                    end
                    write_pos_next   = no;
                    space_left_next  = ns;
                    retired_pos_next = nr;
                    wait_fence_next  = rd_fence;
                    state_next       = S_ALIGN;
                end
            end

            // align the write offset after a fence wait
            S_ALIGN:
            begin
                write_pos_next  = aligned;
                space_left_next = (aligned >= write_pos_reg)
                                  ? sub_sat(space_left_reg, ofs_t'(aligned - write_pos_reg))
                                  : '0;
                wait_valid_next = 1'b1;
                state_next      = S_RESP;
            end

            // hold the result until transferred
            S_RESP:
            begin
                if (out_ready)
                begin
                    if (second_reg)
                    begin
                        second_next      = 1'b0;
                        copy_start_next  = '0;
                        copy_length_next = write_pos_reg;
                        last_next        = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_pos_reg   <= '0;
            space_left_reg  <= '0;
            retired_pos_reg <= '0;
            copied_pos_reg  <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            second_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_pos_reg   <= write_pos_next;
            space_left_reg  <= space_left_next;
            retired_pos_reg <= retired_pos_next;
            copied_pos_reg  <= copied_pos_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            second_reg      <= second_next;
        end
    end

    // captured request and result payload
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        nb_reg          <= nb_next;
        ash_reg         <= ash_next;
        cur_reg         <= cur_next;
        done_reg        <= done_next;
        status_reg      <= status_next;
        wait_valid_reg  <= wait_valid_next;
        wait_fence_reg  <= wait_fence_next;
        copy_valid_reg  <= copy_valid_next;
        copy_start_reg  <= copy_start_next;
        copy_length_reg <= copy_length_next;
        last_reg        <= last_next;
    end

endmodule
